@@ rtl/rcpg_pkg.sv @@
// Shared types, constants and the color wheel function of the rainbow cycle generator.
// No dependencies; used by rcpg_step_unit and rainbow_cycle_pixel_generator_unit.
`default_nettype none

package rcpg_pkg;

  // Field widths
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SPAN_W   = 9;
  localparam int unsigned CYCLES_W = 8;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned STEP_CNT_W = $clog2(SPAN_W + 1);

  // Register indexes on the configuration port
  localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
  localparam logic [1:0] REG_HUE_SPAN    = 2'd1;
  localparam logic [1:0] REG_CYCLES      = 2'd2;

  // Register reset values
  localparam logic [COUNT_W-1:0]  PIXEL_COUNT_RST = 7'd64;
  localparam logic [SPAN_W-1:0]   HUE_SPAN_RST    = 9'd256;
  localparam logic [CYCLES_W-1:0] CYCLES_RST      = 8'd5;

  // Color wheel segment bounds
  localparam logic [7:0] WHEEL_SEG1 = 8'd85;
  localparam logic [7:0] WHEEL_SEG2 = 8'd170;
  localparam logic [7:0] WHEEL_FULL = 8'd255;

  // Operations of the shared step unit
  typedef enum logic [1:0] {
    OP_NONE,
    OP_START,
    OP_DIV,
    OP_ACC
  } step_op_e;

  typedef struct packed {
    step_op_e             op;
    logic [COUNT_W-1:0]   divisor;
    logic [SPAN_W-1:0]    span;
  } step_cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Red-green-blue-back-to-red wheel at an 8-bit position
  function automatic rgb_t wheel(input logic [7:0] pos);
    rgb_t       c;
    logic [7:0] w;
    logic [9:0] w3;
    w = WHEEL_FULL - pos;
    c = '0;
    if (w < WHEEL_SEG1) begin
      w3 = 10'(w) * 10'd3;
      c.red  = WHEEL_FULL - w3[7:0];
      c.blue = w3[7:0];
    end else if (w < WHEEL_SEG2) begin
      w3 = 10'(w - WHEEL_SEG1) * 10'd3;
      c.green = w3[7:0];
      c.blue  = WHEEL_FULL - w3[7:0];
    end else begin
      w3 = 10'(w - WHEEL_SEG2) * 10'd3;
      c.red   = w3[7:0];
      c.green = WHEEL_FULL - w3[7:0];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rcpg_step_unit.sv @@
// Shared compare-and-subtract unit: restoring division of hue_span by the pixel count,
// then per-pixel accumulation of the hue spread. Depends on rcpg_pkg.
`default_nettype none

module rcpg_step_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rcpg_pkg::step_cmd_t               cmd_i,
  output logic [rcpg_pkg::COLOR_W-1:0]           spread_o
);

  localparam int unsigned CW = rcpg_pkg::COUNT_W;
  localparam int unsigned SW = rcpg_pkg::SPAN_W;

  logic [SW-1:0] dvd_q, dvd_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [7:0]    quo_q, quo_d;
  logic [7:0]    acc_q, acc_d;
  logic [CW-1:0] acc_rem_q, acc_rem_d;

  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic          ge;

  // One compare and subtract, shared by division steps and accumulation
  always_comb begin
    if (cmd_i.op == rcpg_pkg::OP_DIV) begin
      trial = {rem_q, dvd_q[SW-1]};
    end else begin
      trial = {1'b0, acc_rem_q} + {1'b0, rem_q};
    end
    ge   = trial >= {1'b0, cmd_i.divisor};
    diff = trial - {1'b0, cmd_i.divisor};
  end

  // Next values per operation
  always_comb begin
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    acc_d     = acc_q;
    acc_rem_d = acc_rem_q;
    unique case (cmd_i.op)
      rcpg_pkg::OP_START: begin
        dvd_d     = cmd_i.span;
        rem_d     = '0;
        quo_d     = '0;
        acc_d     = '0;
        acc_rem_d = '0;
      end
      rcpg_pkg::OP_DIV: begin
        dvd_d = {dvd_q[SW-2:0], 1'b0};
        rem_d = ge ? diff[CW-1:0] : trial[CW-1:0];
        quo_d = {quo_q[6:0], ge};
      end
      rcpg_pkg::OP_ACC: begin
        acc_rem_d = ge ? diff[CW-1:0] : trial[CW-1:0];
        acc_d     = acc_q + quo_q + {7'd0, ge};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      acc_q     <= '0;
      acc_rem_q <= '0;
    end else begin
      dvd_q     <= dvd_d;
      rem_q     <= rem_d;
      quo_q     <= quo_d;
      acc_q     <= acc_d;
      acc_rem_q <= acc_rem_d;
    end
  end

  assign spread_o = acc_q;

  // Both remainders stay below the divisor when accumulating
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rcpg_pkg::OP_ACC |-> rem_q < cmd_i.divisor)
    else $error("division remainder not below pixel count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rcpg_pkg::OP_ACC |-> acc_rem_q < cmd_i.divisor)
    else $error("accumulated remainder not below pixel count");

endmodule

`default_nettype wire

@@ rtl/rainbow_cycle_pixel_generator_unit.sv @@
// Rainbow cycle pixel generator: frame request in, one colored pixel word per LED out.
// Channels: s_axis takes one frame request word, tdata[0] = restart.
// m_axis gives one word per pixel: tdata = {2'b0, blue, green, red, pixel_index},
// tlast marks the final pixel of the frame, tuser = running (offset advanced).
// APB port holds pixel_count (0x0), hue_span (0x4) and cycles (0x8); write only when idle.
// A frame first updates the hue offset, then the shared subtractor divides
// hue_span by the pixel count, then one pixel is emitted per cycle while the
// receiver keeps up, for n pixels, n = pixel count (max 64).
// The input is not ready from acceptance until the last pixel is loaded into the
// output register; the next request is taken while that last word still waits.
// A stalled receiver holds the output word and pauses the pixel sequencer.
// A pixel count of zero updates the offset and emits nothing.
// Reset clears the hue offset and loads pixel_count 64, hue_span 256, cycles 5.
// Depends on rcpg_pkg and rcpg_step_unit.
`default_nettype none

module rainbow_cycle_pixel_generator_unit #(
  parameter int unsigned MAX_PIXELS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Frame requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // Pixel words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [5:0] pixel_index, [13:6] red, [21:14] green,
                                           // [29:22] blue, [31:30] zero
  output logic             m_axis_tlast,
  output logic             m_axis_tuser,   // [0] running
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CW  = rcpg_pkg::COUNT_W;
  localparam int unsigned SW  = rcpg_pkg::SPAN_W;
  localparam int unsigned YW  = rcpg_pkg::CYCLES_W;
  localparam int unsigned OW  = rcpg_pkg::OFFS_W;
  localparam int unsigned IW  = rcpg_pkg::IDX_W;
  localparam int unsigned KW  = rcpg_pkg::STEP_CNT_W;
  localparam int unsigned LW  = SW + YW;
  localparam logic [CW-1:0] MaxPix   = CW'(MAX_PIXELS);
  localparam logic [KW-1:0] LastStep = KW'(SW - 1);
  localparam logic [OW-1:0] OffsTop  = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Configuration registers
  logic [CW-1:0] pixel_count_q;
  logic [SW-1:0] hue_span_q;
  logic [YW-1:0] cycles_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= rcpg_pkg::PIXEL_COUNT_RST;
      hue_span_q    <= rcpg_pkg::HUE_SPAN_RST;
      cycles_q      <= rcpg_pkg::CYCLES_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rcpg_pkg::REG_PIXEL_COUNT: pixel_count_q <= pwdata[CW-1:0];
        rcpg_pkg::REG_HUE_SPAN:    hue_span_q    <= pwdata[SW-1:0];
        rcpg_pkg::REG_CYCLES:      cycles_q      <= pwdata[YW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back registers
  always_comb begin
    unique case (paddr[3:2])
      rcpg_pkg::REG_PIXEL_COUNT: prdata = 32'(pixel_count_q);
      rcpg_pkg::REG_HUE_SPAN:    prdata = 32'(hue_span_q);
      rcpg_pkg::REG_CYCLES:      prdata = 32'(cycles_q);
      default:                   prdata = '0;
    endcase
  end

  // Sequencer state
  state_e        state_q;
  logic          restart_q;
  logic [OW-1:0] hue_offset_q;
  logic          running_q;
  logic [IW-1:0] pix_q;
  logic [KW-1:0] step_q;

  // Output register
  logic          out_valid_q;
  logic [IW-1:0] out_idx_q;
  rcpg_pkg::rgb_t out_rgb_q;
  logic          out_last_q;
  logic          out_run_q;

  logic [CW-1:0] n_sat;
  logic [LW-1:0] limit;
  logic          s_fire;
  logic          out_free;
  logic          emit;
  logic          pix_last;
  logic [7:0]    spread;
  logic [7:0]    pos;
  rcpg_pkg::step_cmd_t cmd;

  assign n_sat    = (pixel_count_q > MaxPix) ? MaxPix : pixel_count_q;
  assign limit    = LW'(hue_span_q) * LW'(cycles_q);
  assign s_fire   = s_axis_tvalid & s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign emit     = (state_q == ST_EMIT) && out_free;
  assign pix_last = {1'b0, pix_q} == (n_sat - CW'(1));
  assign pos      = spread + hue_offset_q[7:0];

  assign s_axis_tready = (state_q == ST_IDLE);

  // Drive the shared unit
  always_comb begin
    cmd.divisor = n_sat;
    cmd.span    = hue_span_q;
    unique case (state_q)
      ST_UPDATE: cmd.op = rcpg_pkg::OP_START;
      ST_DIV:    cmd.op = rcpg_pkg::OP_DIV;
      ST_EMIT:   cmd.op = emit ? rcpg_pkg::OP_ACC : rcpg_pkg::OP_NONE;
      default:   cmd.op = rcpg_pkg::OP_NONE;
    endcase
  end

  rcpg_step_unit u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .spread_o (spread)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      restart_q    <= 1'b0;
      hue_offset_q <= '0;
      running_q    <= 1'b0;
      pix_q        <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_rgb_q    <= '0;
      out_last_q   <= 1'b0;
      out_run_q    <= 1'b0;
    end else begin
      // drop the word once taken, unless a new one replaces it
      if (out_valid_q && m_axis_tready && !emit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            restart_q <= s_axis_tdata[0];
            state_q   <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // clear, advance or hold the hue offset
          if (restart_q) begin
            hue_offset_q <= '0;
            running_q    <= 1'b0;
          end else if ((LW'(hue_offset_q) < limit) && (hue_offset_q != OffsTop)) begin
            hue_offset_q <= hue_offset_q + OW'(1);
            running_q    <= 1'b1;
          end else begin
            running_q <= 1'b0;
          end
          step_q  <= '0;
          pix_q   <= '0;
          state_q <= (n_sat == '0) ? ST_IDLE : ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + KW'(1);
          if (step_q == LastStep) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= pix_q;
            out_rgb_q   <= rcpg_pkg::wheel(pos);
            out_last_q  <= pix_last;
            out_run_q   <= running_q;
            pix_q       <= pix_q + IW'(1);
            if (pix_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red, out_idx_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_run_q;

  // The flagged last pixel carries the final index of the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> ({1'b0, out_idx_q} == (n_sat - CW'(1))))
    else $error("last pixel flag on a word that is not the final index");
  // A restart request leaves the offset at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && restart_q) |=> hue_offset_q == '0)
    else $error("restart did not clear hue offset");
  // Without restart the offset moves by at most one, and running says whether it did
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && !restart_q) |=>
      ((hue_offset_q == $past(hue_offset_q)) && !running_q) ||
      ((hue_offset_q == $past(hue_offset_q) + OW'(1)) && running_q))
    else $error("hue offset update out of step");
  // No new request is taken while pixels of a frame remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !pix_last) |=> !s_axis_tready)
    else $error("request accepted mid-frame");

endmodule

`default_nettype wire
